// ===== hdl/mpid_pkg.sv =====
// Shared constants, command codes and types for the modular power/inverse/divide block.
package mpid_pkg;

    localparam int OPERAND_WIDTH_DEF = 63;
    localparam int MODULUS_WIDTH_DEF = 31;
    localparam int CNT_W             = 7;
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;

    localparam logic [APB_DATA_W-1:0] MODULUS_RESET = 32'd1000000007;

    // register index, taken from paddr[2]
    localparam logic REG_MODULUS = 1'b0;

    localparam logic [1:0] CMD_POW  = 2'd0;
    localparam logic [1:0] CMD_INV  = 2'd1;
    localparam logic [1:0] CMD_DIV  = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    // request to the shared modular multiply unit
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] nbits;
    } t_mm_req;

endpackage

// ===== hdl/mpid_if.sv =====
// Valid/ready channel interfaces for the command beat and the residue beat.
interface mpid_in_if #(
    parameter int OW = mpid_pkg::OPERAND_WIDTH_DEF
);
    logic          valid;
    logic          ready;
    logic [1:0]    cmd;
    logic [OW-1:0] operand_a;
    logic [OW-1:0] operand_b;

    modport source (output valid, output cmd, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input cmd, input operand_a, input operand_b,
                    output ready);
endinterface

interface mpid_out_if #(
    parameter int MW = mpid_pkg::MODULUS_WIDTH_DEF
);
    logic          valid;
    logic          ready;
    logic [MW-1:0] residue;

    modport source (output valid, output residue, input ready);
    modport sink   (input valid, input residue, output ready);
endinterface

// ===== hdl/mpid_apb.sv =====
// APB-style configuration register holding the modulus.
module mpid_apb #(
    parameter int MW = mpid_pkg::MODULUS_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [mpid_pkg::APB_ADDR_W-1:0]   i_paddr,
    input  logic [mpid_pkg::APB_DATA_W-1:0]   i_pwdata,
    output logic [mpid_pkg::APB_DATA_W-1:0]   o_prdata,
    output logic                              o_pready,
    output logic [MW-1:0]                     o_modulus
);
    logic [MW-1:0] r_modulus;
    logic          w_sel_mod;

    assign w_sel_mod = (i_paddr[2] == mpid_pkg::REG_MODULUS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MW'(mpid_pkg::MODULUS_RESET);
        end else if (i_psel && i_penable && i_pwrite && w_sel_mod) begin
            r_modulus <= i_pwdata[MW-1:0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (w_sel_mod) begin
            o_prdata[MW-1:0] = r_modulus;
        end
    end

    assign o_pready  = 1'b1;
    assign o_modulus = r_modulus;
endmodule

// ===== hdl/mpid_modmul.sv =====
// Shared bit-serial interleaved modular multiplier: one multiplier bit per cycle, MSB first.
module mpid_modmul #(
    parameter int OW = mpid_pkg::OPERAND_WIDTH_DEF,
    parameter int MW = mpid_pkg::MODULUS_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mpid_pkg::t_mm_req    i_req,
    input  logic [OW-1:0]        i_mplier,   // left aligned
    input  logic [MW-1:0]        i_mcand,    // below the modulus
    input  logic [MW-1:0]        i_mod,
    output logic                 o_done,
    output logic [MW-1:0]        o_result
);
    logic [mpid_pkg::CNT_W-1:0] r_cnt;
    logic                       r_done;
    logic [MW-1:0]              r_acc;
    logic [MW-1:0]              r_mcand;
    logic [OW-1:0]              r_shift;

    logic [MW+1:0] w_sum;
    logic [MW+1:0] w_m1;
    logic [MW+1:0] w_m2;
    logic [MW+1:0] w_red;

    // acc < m and mcand < m, so 2*acc + mcand < 3m: at most two subtractions
    assign w_m1  = {2'b00, i_mod};
    assign w_m2  = {1'b0, i_mod, 1'b0};
    assign w_sum = {1'b0, r_acc, 1'b0} + (r_shift[OW-1] ? {2'b00, r_mcand} : '0);

    always_comb begin
        if (w_sum >= w_m2) begin
            w_red = w_sum - w_m2;
        end else if (w_sum >= w_m1) begin
            w_red = w_sum - w_m1;
        end else begin
            w_red = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= i_req.nbits;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == mpid_pkg::CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc   <= '0;
            r_shift <= i_mplier;
            r_mcand <= i_mcand;
        end else if (r_cnt != '0) begin
            r_acc   <= w_red[MW-1:0];
            r_shift <= r_shift << 1;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;
endmodule

// ===== hdl/modular_power_inverse_divide.sv =====
// Operation: the base is first reduced modulo m; then each set exponent bit takes a multiply,
// and every bit below the top set bit a square, on the shared bit-serial unit; divide adds a
// reduction of a and a final multiply. When m < 2 the command goes straight to the result.
// Throughput: one command at a time; the next is taken once the sequencer is idle
// again, while the previous residue may still sit in the output register.
// Reset: synchronous, active low; modulus returns to 1000000007, no beat pending.
module modular_power_inverse_divide #(
    parameter int OPERAND_WIDTH = mpid_pkg::OPERAND_WIDTH_DEF,
    parameter int MODULUS_WIDTH = mpid_pkg::MODULUS_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mpid_in_if.sink                           i_in,
    mpid_out_if.source                        o_out,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [mpid_pkg::APB_ADDR_W-1:0]   i_paddr,
    input  logic [mpid_pkg::APB_DATA_W-1:0]   i_pwdata,
    output logic [mpid_pkg::APB_DATA_W-1:0]   o_prdata,
    output logic                              o_pready
);
    localparam int OW = OPERAND_WIDTH;
    localparam int MW = MODULUS_WIDTH;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_RED_BASE = 8'b0000_0010,
        S_CHECK    = 8'b0000_0100,
        S_MUL      = 8'b0000_1000,
        S_SQR      = 8'b0001_0000,
        S_RED_A    = 8'b0010_0000,
        S_FIN_MUL  = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic              r_go, n_go;
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_cmd, n_cmd;
    logic [OW-1:0]     r_base, n_base;
    logic [OW-1:0]     r_exp, n_exp;
    logic [OW-1:0]     r_a, n_a;
    logic [MW-1:0]     r_acc, n_acc;
    logic [MW-1:0]     r_sq, n_sq;
    logic [MW-1:0]     r_res, n_res;
    logic [MW-1:0]     r_out_res, n_out_res;

    logic [MW-1:0]       w_mod;
    logic                w_in_beat;
    mpid_pkg::t_mm_req   w_req;
    logic [OW-1:0]       w_mplier;
    logic [MW-1:0]       w_mcand;
    logic                w_mm_done;
    logic [MW-1:0]       w_mm_res;
    logic [OW-1:0]       w_mexp;

    mpid_apb #(.MW(MW)) u_apb (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_modulus (w_mod)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_beat  = i_in.valid && i_in.ready;
    assign w_mexp     = OW'(w_mod - MW'(2));

    // operand selection for the shared unit, sampled on the start cycle
    always_comb begin
        w_req.start = r_go;
        w_req.nbits = mpid_pkg::CNT_W'(MW);
        w_mplier    = {r_acc, {(OW-MW){1'b0}}};
        w_mcand     = r_sq;
        case (r_state)
            S_RED_BASE: begin
                w_req.nbits = mpid_pkg::CNT_W'(OW);
                w_mplier    = r_base;
                w_mcand     = MW'(1);
            end
            S_RED_A: begin
                w_req.nbits = mpid_pkg::CNT_W'(OW);
                w_mplier    = r_a;
                w_mcand     = MW'(1);
            end
            S_SQR: begin
                w_mplier = {r_sq, {(OW-MW){1'b0}}};
            end
            default: begin
            end
        endcase
    end

    mpid_modmul #(.OW(OW), .MW(MW)) u_modmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_mplier (w_mplier),
        .i_mcand  (w_mcand),
        .i_mod    (w_mod),
        .o_done   (w_mm_done),
        .o_result (w_mm_res)
    );

    always_comb begin
        n_state     = r_state;
        n_go        = 1'b0;
        n_out_valid = r_out_valid;
        n_cmd       = r_cmd;
        n_base      = r_base;
        n_exp       = r_exp;
        n_a         = r_a;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_res       = r_res;
        n_out_res   = r_out_res;

        if (o_out.valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    n_cmd = i_in.cmd;
                    n_a   = i_in.operand_a;
                    n_acc = MW'(1);
                    n_res = '0;
                    if (w_mod < MW'(2) || i_in.cmd == mpid_pkg::CMD_NONE) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RED_BASE;
                        n_go    = 1'b1;
                        case (i_in.cmd)
                            mpid_pkg::CMD_POW: begin
                                n_base = i_in.operand_a;
                                n_exp  = i_in.operand_b;
                            end
                            mpid_pkg::CMD_INV: begin
                                n_base = i_in.operand_a;
                                n_exp  = w_mexp;
                            end
                            default: begin
                                n_base = i_in.operand_b;
                                n_exp  = w_mexp;
                            end
                        endcase
                    end
                end
            end
            S_RED_BASE: begin
                if (w_mm_done) begin
                    n_sq    = w_mm_res;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_exp == '0) begin
                    if (r_cmd == mpid_pkg::CMD_DIV) begin
                        n_state = S_RED_A;
                        n_go    = 1'b1;
                    end else begin
                        n_res   = r_acc;
                        n_state = S_DONE;
                    end
                end else if (r_exp[0]) begin
                    n_state = S_MUL;
                    n_go    = 1'b1;
                end else begin
                    n_state = S_SQR;
                    n_go    = 1'b1;
                end
            end
            S_MUL: begin
                if (w_mm_done) begin
                    n_acc = w_mm_res;
                    if ((r_exp >> 1) == '0) begin
                        // last set bit: the square would go unused
                        n_exp   = '0;
                        n_state = S_CHECK;
                    end else begin
                        n_state = S_SQR;
                        n_go    = 1'b1;
                    end
                end
            end
            S_SQR: begin
                if (w_mm_done) begin
                    n_sq    = w_mm_res;
                    n_exp   = r_exp >> 1;
                    n_state = S_CHECK;
                end
            end
            S_RED_A: begin
                if (w_mm_done) begin
                    n_sq    = w_mm_res;
                    n_state = S_FIN_MUL;
                    n_go    = 1'b1;
                end
            end
            S_FIN_MUL: begin
                if (w_mm_done) begin
                    n_res   = w_mm_res;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_res   = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_go        <= n_go;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_base    <= n_base;
        r_exp     <= n_exp;
        r_a       <= n_a;
        r_acc     <= n_acc;
        r_sq      <= n_sq;
        r_res     <= n_res;
        r_out_res <= n_out_res;
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.residue = r_out_res;
endmodule
